// ===== rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  localparam int MAP_BYTES     = 512;
  localparam int BITS_PER_BYTE = 8;
  localparam int CAPACITY      = MAP_BYTES * BITS_PER_BYTE;

  localparam int WORD_BYTES = 8;
  localparam int WORD_BITS  = WORD_BYTES * BITS_PER_BYTE;
  localparam int MAP_WORDS  = (MAP_BYTES + WORD_BYTES - 1) / WORD_BYTES;
  localparam int WA_W       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int PTR_W      = WA_W + BIT_W;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int BLK_CMP_W  = 17;

  localparam int REQ_W    = 1;
  localparam int BLK_W    = 16;
  localparam int STATUS_W = 2;
  localparam int GRANT_W  = 12;
  localparam int FREE_W   = 13;

  typedef logic [WORD_BITS-1:0] word_t;

  localparam word_t WORD_ONES = {WORD_BITS{1'b1}};
  localparam int    LAST_BITS = CAPACITY - (MAP_WORDS - 1) * WORD_BITS;
  localparam word_t LAST_MASK = WORD_ONES >> (WORD_BITS - LAST_BITS);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_NONE         = 2'd1,
    ST_INVALID      = 2'd2,
    ST_INCONSISTENT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_MOD_LO,
    CAP_MOD_ALL,
    CAP_CUR,
    CAP_MODQ
  } cap_e;

  typedef struct packed {
    logic    accept;
    logic    modify;
    logic    scan_start;
    logic    scan_next;
    logic    set_ptr;
    logic    emit;
    logic    grant;
    status_e status;
    cap_e    cap;
  } cmd_t;

  typedef struct packed {
    logic req_free;
    logic req_free_q;
    logic blk_invalid;
    logic cnt_zero;
    logic cnt_one;
    logic mod_lo_nz;
    logic mod_nz;
    logic modq_nz;
    logic cur_nz;
    logic last_rd;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/bba_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/bba_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bba_ctrl
  import bba_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o,
  output logic      busy_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_BIT
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (!sts_i.req_free && sts_i.cnt_zero) begin
            cmd_o.emit   = 1'b1;
            cmd_o.status = ST_NONE;
          end else if (sts_i.req_free && sts_i.blk_invalid) begin
            cmd_o.emit   = 1'b1;
            cmd_o.status = ST_INVALID;
          end else begin
            cmd_o.accept = 1'b1;
            state_d      = S_MOD;
          end
        end
      end
      S_MOD: begin
        cmd_o.modify = 1'b1;
        if (sts_i.req_free_q) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end else if (sts_i.cnt_one) begin
          cmd_o.emit  = 1'b1;
          cmd_o.grant = 1'b1;
          state_d     = S_IDLE;
        end else if (sts_i.mod_lo_nz) begin
          cmd_o.cap = CAP_MOD_LO;
          state_d   = S_BIT;
        end else if (MAP_WORDS == 1) begin
          if (sts_i.mod_nz) begin
            cmd_o.cap = CAP_MOD_ALL;
            state_d   = S_BIT;
          end else begin
            cmd_o.emit   = 1'b1;
            cmd_o.grant  = 1'b1;
            cmd_o.status = ST_INCONSISTENT;
            state_d      = S_IDLE;
          end
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.cur_nz) begin
          cmd_o.cap = CAP_CUR;
          state_d   = S_BIT;
        end else if (sts_i.last_rd) begin
          if (sts_i.modq_nz) begin
            cmd_o.cap = CAP_MODQ;
            state_d   = S_BIT;
          end else begin
            cmd_o.emit   = 1'b1;
            cmd_o.grant  = 1'b1;
            cmd_o.status = ST_INCONSISTENT;
            state_d      = S_IDLE;
          end
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      S_BIT: begin
        cmd_o.set_ptr = 1'b1;
        cmd_o.emit    = 1'b1;
        cmd_o.grant   = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire

// ===== rtl/bba_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bba_dp
  import bba_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [REQ_W-1:0]   req_type_i,
  input  wire logic [BLK_W-1:0]   block_number_i,
  input  wire cmd_t               cmd_i,
  output sts_t                    sts_o,
  output logic                    done_o,
  output logic [STATUS_W-1:0]     status_o,
  output logic [GRANT_W-1:0]      granted_block_o,
  output logic [FREE_W-1:0]       blocks_free_o
);

  function automatic logic [WA_W-1:0] next_word(logic [WA_W-1:0] a);
    return (a == WA_W'(MAP_WORDS - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [2:0] low_bit(logic [BITS_PER_BYTE-1:0] v);
    logic [2:0] r;
    r = '0;
    for (int i = BITS_PER_BYTE - 1; i >= 0; i--) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

  logic [CNT_W-1:0]         count_q, count_d;
  logic [PTR_W-1:0]         ptr_q, ptr_d;
  logic [PTR_W-1:0]         tgt_q, tgt_d;
  logic                     req_free_q, req_free_d;
  logic [WA_W-1:0]          rd_addr_q, rd_addr_d;
  logic [WA_W-1:0]          rd_left_q, rd_left_d;
  logic [MAP_WORDS-1:0]     valid_q, valid_d;
  word_t                    mod_word_q, mod_word_d;
  logic [WA_W-1:0]          w0_q, w0_d;
  logic [WA_W-1:0]          hit_word_q, hit_word_d;
  logic [2:0]               hit_byte_q, hit_byte_d;
  logic [BITS_PER_BYTE-1:0] hit_val_q, hit_val_d;
  logic                     done_q;
  status_e                  status_q;
  logic [GRANT_W-1:0]       grant_q;
  logic [FREE_W-1:0]        free_q;

  logic [PTR_W-1:0] blk_ext;
  word_t            ram_rdata;
  word_t            cur_word;
  word_t            mod_word;
  word_t            mod_lo;
  word_t            bit_sel;
  word_t            cap_word;
  logic [WA_W-1:0]  cap_widx;
  logic [2:0]       pick;

  assign blk_ext = PTR_W'(block_number_i);

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (cmd_i.modify),
    .waddr_i (rd_addr_q),
    .wdata_i (mod_word),
    .raddr_i (rd_addr_d),
    .rdata_o (ram_rdata)
  );

  // unwritten words read as all free; bits past capacity never count
  always_comb begin
    cur_word = valid_q[rd_addr_q] ? ram_rdata : WORD_ONES;
    if (rd_addr_q == WA_W'(MAP_WORDS - 1)) begin
      cur_word = cur_word & LAST_MASK;
    end
    bit_sel  = word_t'(1) << tgt_q[BIT_W-1:0];
    mod_word = req_free_q ? (cur_word | bit_sel) : (cur_word & ~bit_sel);
    mod_lo   = mod_word & (WORD_ONES << {tgt_q[BIT_W-1:3], 3'b000});
  end

  always_comb begin
    sts_o.req_free    = req_type_i[0];
    sts_o.req_free_q  = req_free_q;
    sts_o.blk_invalid = ({1'b0, block_number_i} >= BLK_CMP_W'(CAPACITY));
    sts_o.cnt_zero    = (count_q == '0);
    sts_o.cnt_one     = (count_q == CNT_W'(1));
    sts_o.mod_lo_nz   = (mod_lo != '0);
    sts_o.mod_nz      = (mod_word != '0);
    sts_o.modq_nz     = (mod_word_q != '0);
    sts_o.cur_nz      = (cur_word != '0);
    sts_o.last_rd     = (rd_left_q == WA_W'(1));
  end

  always_comb begin
    if (cmd_i.accept) begin
      rd_addr_d = req_type_i[0] ? blk_ext[PTR_W-1:BIT_W] : ptr_q[PTR_W-1:BIT_W];
    end else if (cmd_i.scan_start || cmd_i.scan_next) begin
      rd_addr_d = next_word(rd_addr_q);
    end else begin
      rd_addr_d = rd_addr_q;
    end
  end

  always_comb begin
    case (cmd_i.cap)
      CAP_MOD_LO:  begin cap_word = mod_lo;     cap_widx = rd_addr_q; end
      CAP_MOD_ALL: begin cap_word = mod_word;   cap_widx = rd_addr_q; end
      CAP_CUR:     begin cap_word = cur_word;   cap_widx = rd_addr_q; end
      CAP_MODQ:    begin cap_word = mod_word_q; cap_widx = w0_q;      end
      default:     begin cap_word = mod_word_q; cap_widx = w0_q;      end
    endcase
    pick = '0;
    for (int i = WORD_BYTES - 1; i >= 0; i--) begin
      if (cap_word[i*BITS_PER_BYTE +: BITS_PER_BYTE] != '0) pick = 3'(i);
    end
  end

  always_comb begin
    count_d    = count_q;
    ptr_d      = ptr_q;
    tgt_d      = tgt_q;
    req_free_d = req_free_q;
    rd_left_d  = rd_left_q;
    valid_d    = valid_q;
    mod_word_d = mod_word_q;
    w0_d       = w0_q;
    hit_word_d = hit_word_q;
    hit_byte_d = hit_byte_q;
    hit_val_d  = hit_val_q;

    if (cmd_i.accept) begin
      req_free_d = req_type_i[0];
      tgt_d      = req_type_i[0] ? blk_ext : ptr_q;
    end

    if (cmd_i.modify) begin
      valid_d[rd_addr_q] = 1'b1;
      mod_word_d         = mod_word;
      w0_d               = rd_addr_q;
      if (req_free_q) begin
        if (count_q == '0) ptr_d = tgt_q;
        if (count_q < CNT_W'(CAPACITY)) count_d = count_q + 1'b1;
      end else begin
        count_d = count_q - 1'b1;
      end
    end

    if (cmd_i.scan_start) begin
      rd_left_d = WA_W'(MAP_WORDS - 1);
    end else if (cmd_i.scan_next) begin
      rd_left_d = rd_left_q - 1'b1;
    end

    if (cmd_i.cap != CAP_NONE) begin
      hit_word_d = cap_widx;
      hit_byte_d = pick;
      hit_val_d  = cap_word[pick*BITS_PER_BYTE +: BITS_PER_BYTE];
    end

    if (cmd_i.set_ptr) begin
      ptr_d = {hit_word_q, hit_byte_q, low_bit(hit_val_q)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= CNT_W'(CAPACITY);
      ptr_q     <= '0;
      valid_q   <= '0;
      rd_addr_q <= '0;
      rd_left_q <= '0;
      done_q    <= 1'b0;
    end else begin
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      valid_q   <= valid_d;
      rd_addr_q <= rd_addr_d;
      rd_left_q <= rd_left_d;
      done_q    <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q      <= tgt_d;
    req_free_q <= req_free_d;
    mod_word_q <= mod_word_d;
    w0_q       <= w0_d;
    hit_word_q <= hit_word_d;
    hit_byte_q <= hit_byte_d;
    hit_val_q  <= hit_val_d;
    if (cmd_i.emit) begin
      status_q <= cmd_i.status;
      grant_q  <= cmd_i.grant ? GRANT_W'(tgt_q) : '0;
      free_q   <= FREE_W'(count_d);
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign granted_block_o = grant_q;
  assign blocks_free_o   = free_q;

endmodule

`default_nettype wire

// ===== rtl/bitmap_block_allocator_unit.sv =====
// Flow: a rejected request is answered from idle, a free passes through the modify state,
// and an allocate may add the scan state and then the bit-pick state to find the next free block.
// Throughput is set by the next-free scan, one 64-bit map word read from RAM per cycle.
// A new request is taken once busy_o drops; done_o marks each beat for one cycle, no stall.
// Reset: async active low; all blocks free, count at capacity, pointer at zero.
// Per-word valid flops stand in for the map's all-free reset, so no clearing pass is run.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_block_allocator_unit
  import bba_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [REQ_W-1:0]    req_type_i,
  input  wire logic [BLK_W-1:0]    block_number_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [GRANT_W-1:0]       granted_block_o,
  output logic [FREE_W-1:0]        blocks_free_o
);

  cmd_t cmd;
  sts_t sts;

  bba_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  bba_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_type_i      (req_type_i),
    .block_number_i  (block_number_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .done_o          (done_o),
    .status_o        (status_o),
    .granted_block_o (granted_block_o),
    .blocks_free_o   (blocks_free_o)
  );

endmodule

`default_nettype wire

// ===== bench/bitmap_alloc_checker.sv =====
`timescale 1ns / 1ps

module bitmap_alloc_checker
  import bba_pkg::*;
#(
  parameter logic [REQ_W-1:0] FREE_REQ = '1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [REQ_W-1:0]    req_type_i,
  input  wire logic [BLK_W-1:0]    block_number_i,
  input  wire logic                busy_i,
  input  wire logic                done_i,
  input  wire logic [STATUS_W-1:0] status_i,
  input  wire logic [GRANT_W-1:0]  granted_block_i,
  input  wire logic [FREE_W-1:0]   blocks_free_i,
  output int                       error_count_o,
  output int                       pending_o
);

  typedef struct packed {
    status_e             status;
    logic [GRANT_W-1:0]  granted;
    logic [FREE_W-1:0]   free_cnt;
  } alloc_beat_t;

  logic [CAPACITY-1:0] map_free = '1;
  int                  free_blocks = CAPACITY;
  int                  next_ptr = 0;
  alloc_beat_t         expected_beats[$];

  initial begin
    error_count_o = 0;
    pending_o     = 0;
  end

  task automatic note_error(input string msg);
    error_count_o++;
    if (error_count_o <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  // next-fit allocator: hands out next_ptr, then scans bytes forward with wrap
  task automatic predict_request(input logic is_free, input logic [BLK_W-1:0] blk,
                                 output alloc_beat_t beat);
    int g;
    int home;
    int hit;
    int lo;
    beat.status  = ST_OK;
    beat.granted = '0;
    if (!is_free) begin
      if (free_blocks == 0) begin
        beat.status = ST_NONE;
      end else begin
        g            = next_ptr % CAPACITY;
        home         = g / BITS_PER_BYTE;
        map_free[g]  = 1'b0;
        free_blocks--;
        beat.granted = g[GRANT_W-1:0];
        if (free_blocks != 0) begin
          hit = -1;
          for (int i = home; i < MAP_BYTES; i++)
            if (hit < 0 && map_free[i*BITS_PER_BYTE +: BITS_PER_BYTE] != '0) hit = i;
          for (int i = 0; i < home; i++)
            if (hit < 0 && map_free[i*BITS_PER_BYTE +: BITS_PER_BYTE] != '0) hit = i;
          if (hit < 0) begin
            beat.status = ST_INCONSISTENT;
          end else begin
            lo = 0;
            for (int k = BITS_PER_BYTE - 1; k >= 0; k--)
              if (map_free[hit*BITS_PER_BYTE + k]) lo = k;
            next_ptr = hit * BITS_PER_BYTE + lo;
          end
        end
      end
    end else if (blk >= CAPACITY) begin
      beat.status = ST_INVALID;
    end else begin
      if (free_blocks == 0) next_ptr = blk;
      if (free_blocks < CAPACITY) free_blocks++;
      map_free[blk] = 1'b1;
    end
    beat.free_cnt = free_blocks[FREE_W-1:0];
  endtask

  always @(posedge clk_i) begin
    alloc_beat_t want;
    alloc_beat_t got;
    if (!rst_ni) begin
      map_free    = '1;
      free_blocks = CAPACITY;
      next_ptr    = 0;
      expected_beats.delete();
    end else begin
      if (done_i) begin
        got = '{status_e'(status_i), granted_block_i, blocks_free_i};
        if (expected_beats.size() == 0) begin
          note_error($sformatf("unexpected result beat: status %0d granted %0d free %0d",
                               got.status, got.granted, got.free_cnt));
        end else begin
          want = expected_beats.pop_front();
          if (got != want)
            note_error($sformatf({"mismatch: status %0d/%0d granted %0d/%0d ",
                                  "free %0d/%0d (expected/actual)"},
                                 want.status, got.status, want.granted, got.granted,
                                 want.free_cnt, got.free_cnt));
        end
      end
      if (start_i && !busy_i) begin
        predict_request(req_type_i == FREE_REQ, block_number_i, want);
        expected_beats.push_back(want);
      end
    end
    pending_o = expected_beats.size();
  end

endmodule

// ===== bench/tb_bitmap_block_allocator_unit.sv =====
`timescale 1ns / 1ps

module tb_bitmap_block_allocator_unit;
  import bba_pkg::*;

  localparam logic [REQ_W-1:0] REQ_ALLOC = 1'b0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 1'b1;
  localparam int STALL_LIMIT = 2000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic [REQ_W-1:0]    req_type_i = REQ_ALLOC;
  logic [BLK_W-1:0]    block_number_i = '0;
  logic                busy_o;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [GRANT_W-1:0]  granted_block_o;
  logic [FREE_W-1:0]   blocks_free_o;

  int mismatches;
  int outstanding;
  int idle_cycles = 0;
  int est_free = CAPACITY;
  int burst_left = 0;
  logic last_was_alloc = 1'b0;
  int granted_pool[$];

  always #4 clk_i = ~clk_i;

  bitmap_block_allocator_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .req_type_i      (req_type_i),
    .block_number_i  (block_number_i),
    .busy_o          (busy_o),
    .done_o          (done_o),
    .status_o        (status_o),
    .granted_block_o (granted_block_o),
    .blocks_free_o   (blocks_free_o)
  );

  bitmap_alloc_checker #(.FREE_REQ(REQ_FREE)) alloc_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .req_type_i      (req_type_i),
    .block_number_i  (block_number_i),
    .busy_i          (busy_o),
    .done_i          (done_o),
    .status_i        (status_o),
    .granted_block_i (granted_block_o),
    .blocks_free_i   (blocks_free_o),
    .error_count_o   (mismatches),
    .pending_o       (outstanding)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // granted blocks are kept so later frees return real allocations
  always @(posedge clk_i) begin
    if (done_o && last_was_alloc && status_o != ST_NONE)
      granted_pool.push_back(int'(granted_block_o));
    if (start_i && !busy_o) last_was_alloc <= (req_type_i == REQ_ALLOC);
  end

  task automatic issue(input logic [REQ_W-1:0] rt, input logic [BLK_W-1:0] bn);
    bit taken;
    if (burst_left == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256)
                                                : $urandom_range(1, 20);
    end
    burst_left--;
    start_i        <= 1'b1;
    req_type_i     <= rt;
    block_number_i <= bn;
    if (rt == REQ_ALLOC) begin
      if (est_free > 0) est_free--;
    end else if (bn < CAPACITY && est_free < CAPACITY) begin
      est_free++;
    end
    do begin
      taken = !busy_o;
      @(negedge clk_i);
    end while (!taken);
  endtask

  function automatic logic [BLK_W-1:0] pick_free_block();
    int sel;
    int idx;
    logic [BLK_W-1:0] blk;
    sel = $urandom_range(0, 99);
    if (sel < 45 && granted_pool.size() > 0) begin
      idx = $urandom_range(0, granted_pool.size() - 1);
      blk = BLK_W'(granted_pool[idx]);
      granted_pool.delete(idx);
    end else if (sel < 80) begin
      blk = BLK_W'($urandom_range(0, CAPACITY - 1));
    end else if (sel < 90) begin
      blk = BLK_W'($urandom_range(CAPACITY, 65535));
    end else begin
      blk = BLK_W'($urandom());
    end
    return blk;
  endfunction

  initial begin
    int guard;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    issue(REQ_ALLOC, 16'h0000);
    issue(REQ_ALLOC, 16'hFFFF);
    issue(REQ_FREE,  16'd4095);
    issue(REQ_FREE,  16'd0);
    issue(REQ_FREE,  16'd0);
    issue(REQ_FREE,  16'd4096);
    issue(REQ_FREE,  16'hFFFF);
    issue(REQ_FREE,  16'h5555);
    issue(REQ_FREE,  16'h0AAA);
    issue(REQ_ALLOC, 16'hAAAA);
    issue(REQ_ALLOC, 16'h0000);
    issue(REQ_ALLOC, 16'h1000);
    issue(REQ_FREE,  16'd2);
    issue(REQ_ALLOC, 16'h0000);

    // mixed traffic, double frees inflate the count
    repeat (500) begin
      if ($urandom_range(0, 99) < 55) issue(REQ_ALLOC, BLK_W'($urandom()));
      else issue(REQ_FREE, pick_free_block());
    end

    // allocate-heavy run: the pointer walks forward across map words
    guard = 0;
    while (est_free > 0 && guard < 936) begin
      if ($urandom_range(0, 99) < 94) issue(REQ_ALLOC, BLK_W'($urandom()));
      else issue(REQ_FREE, pick_free_block());
      guard++;
    end

    // balanced traffic with returned and out-of-range frees
    repeat (300) begin
      if ($urandom_range(0, 1) == 0) issue(REQ_ALLOC, BLK_W'($urandom()));
      else issue(REQ_FREE, pick_free_block());
    end

    start_i <= 1'b0;
    wait (outstanding == 0);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
